// File: rtl/core/tesd_pkg.sv
// ----------------------------------------------------------------------------
// tesd_pkg: terminal escape sequence decoder package
// Types, byte codes, key ids and helper functions of the decoder.
// ----------------------------------------------------------------------------
package tesd_pkg;

    localparam int PARAM_LIMIT = 32;
    localparam int PARAM_BITS  = 16;
    localparam int TOTAL_W     = $clog2(PARAM_LIMIT + 1);
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

    typedef enum logic [1:0] {
        MODE_GROUND,
        MODE_ESC,
        MODE_SS3,
        MODE_CSI
    } t_mode;

    typedef enum logic [1:0] {
        PFX_NONE,
        PFX_QUERY,
        PFX_GT,
        PFX_LT
    } t_prefix;

    localparam logic CFG_GAIN  = 1'b0;
    localparam logic CFG_CLAMP = 1'b1;

    localparam logic [2:0] EV_KEY    = 3'd0;
    localparam logic [2:0] EV_MOVE   = 3'd1;
    localparam logic [2:0] EV_BUTTON = 3'd2;
    localparam logic [2:0] EV_CURSOR = 3'd3;
    localparam logic [2:0] EV_CELL   = 3'd4;
    localparam logic [2:0] EV_ATTR   = 3'd5;
    localparam logic [2:0] EV_EXIT   = 3'd6;

    localparam logic [8:0] K_NONE  = 9'd0;
    localparam logic [8:0] K_ENTER = 9'd256;
    localparam logic [8:0] K_FIRE  = 9'd257;
    localparam logic [8:0] K_UP    = 9'd258;
    localparam logic [8:0] K_DOWN  = 9'd259;
    localparam logic [8:0] K_LEFT  = 9'd260;
    localparam logic [8:0] K_RIGHT = 9'd261;
    localparam logic [8:0] K_F1    = 9'd262;
    localparam logic [8:0] K_SHIFT = 9'd274;

    localparam logic [7:0] CH_CTRL_C = 8'd3;
    localparam logic [7:0] CH_LF     = 8'd10;
    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_ESC    = 8'd27;
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_DEL    = 8'd127;
    localparam logic [7:0] CH_LO_F   = "f";
    localparam logic [7:0] CH_UP_F   = "F";
    localparam logic [7:0] CH_LO_I   = "i";
    localparam logic [7:0] CH_UP_I   = "I";
    localparam logic [7:0] CH_SS3    = "O";
    localparam logic [7:0] CH_CSI    = "[";
    localparam logic [7:0] CH_P      = "P";
    localparam logic [7:0] CH_S      = "S";
    localparam logic [7:0] CH_QUERY  = "?";
    localparam logic [7:0] CH_GT     = ">";
    localparam logic [7:0] CH_LT     = "<";
    localparam logic [7:0] CH_0      = "0";
    localparam logic [7:0] CH_9      = "9";
    localparam logic [7:0] CH_SEMI   = ";";
    localparam logic [7:0] CH_DA     = "c";
    localparam logic [7:0] CH_WINOP  = "t";
    localparam logic [7:0] CH_CPR    = "R";
    localparam logic [7:0] CH_MPRESS = "M";
    localparam logic [7:0] CH_MREL   = "m";
    localparam logic [7:0] CH_A      = "A";
    localparam logic [7:0] CH_B      = "B";
    localparam logic [7:0] CH_C      = "C";
    localparam logic [7:0] CH_D      = "D";
    localparam logic [7:0] CH_TILDE  = "~";

    typedef struct packed {
        logic [2:0]         kind;
        logic [8:0]         key;
        logic [2:0]         mods;
        logic               hold;
        logic signed [12:0] mx;
        logic signed [12:0] my;
        logic [15:0]        r1;
        logic [15:0]        r2;
        logic               last;
    } t_event;

    function automatic t_event mk_event(input logic [2:0] kind, input logic [8:0] key,
                                        input logic [2:0] mods, input logic hold,
                                        input logic [12:0] mx, input logic [12:0] my,
                                        input logic [15:0] r1, input logic [15:0] r2);
        t_event e;
        e.kind = kind;
        e.key  = key;
        e.mods = mods;
        e.hold = hold;
        e.mx   = $signed(mx);
        e.my   = $signed(my);
        e.r1   = r1;
        e.r2   = r2;
        e.last = 1'b0;
        return e;
    endfunction

    function automatic logic [8:0] plain_key_id(input logic [7:0] b);
        logic [8:0] k;
        k = {1'b0, b};
        if (b == CH_CR || b == CH_LF) begin
            k = K_ENTER;
        end
        if (b == CH_SPACE || b == CH_LO_F || b == CH_UP_F || b == CH_LO_I || b == CH_UP_I) begin
            k = K_FIRE;
        end
        return k;
    endfunction

    function automatic logic [8:0] tilde_key(input logic [PARAM_BITS-1:0] p);
        logic [8:0] k;
        k = K_NONE;
        if (p == PARAM_BITS'(15)) k = K_F1 + 9'd4;
        if (p == PARAM_BITS'(17)) k = K_F1 + 9'd5;
        if (p == PARAM_BITS'(18)) k = K_F1 + 9'd6;
        if (p == PARAM_BITS'(19)) k = K_F1 + 9'd7;
        if (p == PARAM_BITS'(20)) k = K_F1 + 9'd8;
        if (p == PARAM_BITS'(21)) k = K_F1 + 9'd9;
        if (p == PARAM_BITS'(23)) k = K_F1 + 9'd10;
        if (p == PARAM_BITS'(24)) k = K_F1 + 9'd11;
        return k;
    endfunction

endpackage

// File: rtl/core/terminal_escape_sequence_decoder.sv
// ----------------------------------------------------------------------------
// terminal_escape_sequence_decoder
// Decodes terminal bytes into key, mouse, report and exit events.
// ----------------------------------------------------------------------------
// Input channel: one raw byte per transfer (i_in_valid / o_in_ready).
// Output channel: one event per transfer (o_out_valid / i_out_ready); a byte
// causes zero, one or two events, the last flagged by o_last_of_run.
// Config port: i_cfg_we with i_cfg_index 0 sets the mouse gain (data[3:0]),
// index 1 sets the mouse clamp (data[7:0]). Write only while idle.
// A byte lands in an input register; once the queue has room for two events it
// is decoded in one pass and its events are written to a four-entry event queue,
// which presents the first event on the output port. One byte is taken per cycle
// as long as the queue holds at most two events at the start of the cycle, so
// o_in_ready does not depend on i_out_ready; the output port then sets the
// sustained rate, one event per cycle while i_out_ready is high.
// When the receiver stalls, the queue fills and o_in_ready drops; the byte in
// the input register waits and nothing is lost.
// Reset: parser back to ground state, mouse tracking and buttons cleared,
// gain 10, clamp 100, queue empty.
// ----------------------------------------------------------------------------
module terminal_escape_sequence_decoder
    import tesd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [7:0]         i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_in_byte,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [2:0]         o_event_kind,
    output logic [8:0]         o_key_id,
    output logic [2:0]         o_mod_bits,
    output logic               o_hold_long,
    output logic signed [12:0] o_move_x,
    output logic signed [12:0] o_move_y,
    output logic [15:0]        o_report_first,
    output logic [15:0]        o_report_second,
    output logic               o_last_of_run
);

    logic [3:0]             r_gain;
    logic [7:0]             r_clamp;
    logic                   r_in_valid;
    logic [7:0]             r_in_byte;

    t_mode                  r_mode,    n_mode;
    logic [PARAM_BITS-1:0]  r_pv [3];
    logic [PARAM_BITS-1:0]  n_pv [3];
    logic [TOTAL_W-1:0]     r_total,   n_total;
    logic [PARAM_BITS-1:0]  r_accum,   n_accum;
    t_prefix                r_prefix,  n_prefix;
    logic [15:0]            r_last_col, n_last_col;
    logic [15:0]            r_last_row, n_last_row;
    logic                   r_tracking, n_tracking;
    logic [2:0]             r_down,    n_down;

    t_event                 r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0]     r_wr;
    logic [FIFO_AW-1:0]     r_rd;
    logic [FIFO_AW:0]       r_count;

    t_event                 ev0, ev1;
    logic [1:0]             ev_n;

    logic                   pop, proc;
    logic [FIFO_AW:0]       count_after_pop;

    logic [7:0]             b;
    logic                   total_lt;
    logic [TOTAL_W-1:0]     st_total;
    logic [PARAM_BITS-1:0]  pv_eff [3];
    logic [PARAM_BITS-1:0]  p0, p1;
    logic [PARAM_BITS+3:0]  acc_next;
    logic [PARAM_BITS-1:0]  acc_sat;
    logic                   is_digit, is_final, is_mouse_final, press;
    logic                   mouse_ok, moved, btn_ok, btn_edge, btn_rel;
    logic [1:0]             btn;
    logic [2:0]             btn_bit;
    logic [8:0]             btn_key;
    logic signed [16:0]     dx_raw, dy_raw, clamp_s;
    logic signed [16:0]     dx_cl, dy_cl;
    logic signed [13:0]     dx_prod, dy_prod;
    logic [8:0]             csi_key;
    logic                   csi_hold;
    logic [2:0]             csi_mods;

    // ---------------------------------------------------------------- decode
    assign b        = r_in_byte;
    assign total_lt = r_total < TOTAL_W'(PARAM_LIMIT);
    assign st_total = total_lt ? r_total + TOTAL_W'(1) : r_total;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pv_eff[i] = (total_lt && r_total == TOTAL_W'(i)) ? r_accum : r_pv[i];
        end
    end

    assign p0 = (st_total > TOTAL_W'(0)) ? pv_eff[0] : '0;
    assign p1 = (st_total > TOTAL_W'(1)) ? pv_eff[1] : '0;

    assign acc_next = r_accum * (PARAM_BITS+4)'(10) + (PARAM_BITS+4)'(b - CH_0);
    assign acc_sat  = (acc_next > (PARAM_BITS+4)'({PARAM_BITS{1'b1}})) ?
                      {PARAM_BITS{1'b1}} : acc_next[PARAM_BITS-1:0];

    assign is_digit = (b >= CH_0) && (b <= CH_9);
    assign is_final = !(b == CH_QUERY || b == CH_GT || b == CH_LT || is_digit || b == CH_SEMI);
    assign is_mouse_final = (b == CH_MPRESS || b == CH_MREL) && (r_prefix == PFX_LT);
    assign press = (b == CH_MPRESS);

    assign mouse_ok = is_mouse_final && (st_total >= TOTAL_W'(3)) && !pv_eff[0][6];

    assign clamp_s = $signed({9'd0, r_clamp});
    assign dx_raw  = $signed({1'b0, 16'(pv_eff[1])}) - $signed({1'b0, r_last_col});
    assign dy_raw  = $signed({1'b0, 16'(pv_eff[2])}) - $signed({1'b0, r_last_row});
    assign dx_cl   = (dx_raw > clamp_s) ? clamp_s : ((dx_raw < -clamp_s) ? -clamp_s : dx_raw);
    assign dy_cl   = (dy_raw > clamp_s) ? clamp_s : ((dy_raw < -clamp_s) ? -clamp_s : dy_raw);
    assign dx_prod = $signed(dx_cl[8:0]) * $signed({1'b0, r_gain});
    assign dy_prod = $signed(dy_cl[8:0]) * $signed({1'b0, r_gain});
    assign moved   = (dx_prod != 14'sd0) || (dy_prod != 14'sd0);

    assign btn      = pv_eff[0][1:0];
    assign btn_bit  = 3'b001 << btn;
    assign btn_ok   = mouse_ok && r_tracking && !pv_eff[0][5] && (btn != 2'd3);
    assign btn_edge = btn_ok && press && ((r_down & btn_bit) == 3'd0);
    assign btn_rel  = btn_ok && !press && ((r_down & btn_bit) != 3'd0);
    assign btn_key  = (btn == 2'd0) ? K_FIRE : ((btn == 2'd1) ? K_SHIFT : {1'b0, CH_SPACE});

    always_comb begin
        csi_key  = K_NONE;
        csi_hold = 1'b0;
        case (b)
            CH_A:     begin csi_key = K_UP;    csi_hold = 1'b1; end
            CH_B:     begin csi_key = K_DOWN;  csi_hold = 1'b1; end
            CH_C:     begin csi_key = K_RIGHT; csi_hold = 1'b1; end
            CH_D:     begin csi_key = K_LEFT;  csi_hold = 1'b1; end
            CH_TILDE: csi_key = tilde_key(p0);
            default:  ;
        endcase
        csi_mods = (p1 >= PARAM_BITS'(2)) ? 3'(p1 - PARAM_BITS'(1)) : 3'd0;
    end

    // ------------------------------------------------------------ next state
    always_comb begin
        n_mode     = r_mode;
        n_pv       = r_pv;
        n_total    = r_total;
        n_accum    = r_accum;
        n_prefix   = r_prefix;
        n_last_col = r_last_col;
        n_last_row = r_last_row;
        n_tracking = r_tracking;
        n_down     = r_down;
        if (b == CH_CTRL_C) begin
        end else if (b == CH_ESC) begin
            n_mode = MODE_ESC;
        end else begin
            case (r_mode)
                MODE_GROUND: ;
                MODE_ESC: begin
                    if (b == CH_SS3) begin
                        n_mode = MODE_SS3;
                    end else if (b == CH_CSI) begin
                        n_mode   = MODE_CSI;
                        n_accum  = '0;
                        n_total  = '0;
                        n_prefix = PFX_NONE;
                    end else begin
                        n_mode = MODE_GROUND;
                    end
                end
                MODE_SS3: n_mode = MODE_GROUND;
                MODE_CSI: begin
                    if (b == CH_QUERY) begin
                        n_prefix = PFX_QUERY;
                    end else if (b == CH_GT) begin
                        n_prefix = PFX_GT;
                    end else if (b == CH_LT) begin
                        n_prefix = PFX_LT;
                    end else if (is_digit) begin
                        n_accum = acc_sat;
                    end else begin
                        n_total = st_total;
                        if (total_lt && r_total < TOTAL_W'(3)) begin
                            n_pv[r_total[1:0]] = r_accum;
                        end
                        if (b == CH_SEMI) begin
                            n_accum = '0;
                        end else begin
                            n_mode = MODE_GROUND;
                            if (mouse_ok) begin
                                if (!r_tracking || moved) begin
                                    n_last_col = 16'(pv_eff[1]);
                                    n_last_row = 16'(pv_eff[2]);
                                end
                                n_tracking = 1'b1;
                                if (btn_edge) n_down = r_down | btn_bit;
                                if (btn_rel)  n_down = r_down & ~btn_bit;
                            end
                        end
                    end
                end
                default: n_mode = MODE_GROUND;
            endcase
        end
    end

    // ---------------------------------------------------------------- events
    always_comb begin
        t_event key27;
        key27 = mk_event(EV_KEY, {1'b0, CH_ESC}, 3'd0, 1'b0, '0, '0, '0, '0);
        ev0   = mk_event(EV_KEY, K_NONE, 3'd0, 1'b0, '0, '0, '0, '0);
        ev1   = ev0;
        ev_n  = 2'd0;
        if (b == CH_CTRL_C) begin
            ev0  = mk_event(EV_EXIT, K_NONE, 3'd0, 1'b0, '0, '0, '0, '0);
            ev_n = 2'd1;
        end else if (b == CH_ESC) begin
            if (r_mode == MODE_ESC) begin
                ev0  = key27;
                ev_n = 2'd1;
            end
        end else begin
            case (r_mode)
                MODE_GROUND: begin
                    ev0  = mk_event(EV_KEY, plain_key_id(b), 3'd0, 1'b0, '0, '0, '0, '0);
                    ev_n = 2'd1;
                end
                MODE_ESC: begin
                    if (b != CH_SS3 && b != CH_CSI) begin
                        ev0  = key27;
                        ev_n = 2'd1;
                        if (b >= CH_SPACE && b < CH_DEL) begin
                            ev1  = mk_event(EV_KEY, plain_key_id(b), 3'd0, 1'b0,
                                            '0, '0, '0, '0);
                            ev_n = 2'd2;
                        end
                    end
                end
                MODE_SS3: begin
                    if (b >= CH_P && b <= CH_S) begin
                        ev0  = mk_event(EV_KEY, K_F1 + 9'(b - CH_P), 3'd0, 1'b0,
                                        '0, '0, '0, '0);
                        ev_n = 2'd1;
                    end
                end
                MODE_CSI: begin
                    if (is_final) begin
                        if (b == CH_DA && r_prefix == PFX_QUERY) begin
                            ev0  = mk_event(EV_ATTR, K_NONE, 3'd0, 1'b0, '0, '0,
                                            16'(st_total), '0);
                            ev_n = 2'd1;
                        end else if (b == CH_WINOP) begin
                            if (st_total >= TOTAL_W'(3) && pv_eff[0] == PARAM_BITS'(4)) begin
                                ev0  = mk_event(EV_CELL, K_NONE, 3'd0, 1'b0, '0, '0,
                                                16'(pv_eff[1]), 16'(pv_eff[2]));
                                ev_n = 2'd1;
                            end
                        end else if (b == CH_CPR) begin
                            if (st_total >= TOTAL_W'(2)) begin
                                ev0  = mk_event(EV_CURSOR, K_NONE, 3'd0, 1'b0, '0, '0,
                                                16'(pv_eff[0]), 16'(pv_eff[1]));
                                ev_n = 2'd1;
                            end
                        end else if (b == CH_MPRESS || b == CH_MREL) begin
                            if (mouse_ok && r_tracking) begin
                                if (moved) begin
                                    ev0  = mk_event(EV_MOVE, K_NONE, 3'd0, 1'b0,
                                                    dx_prod[12:0], dy_prod[12:0], '0, '0);
                                    ev_n = 2'd1;
                                    if (btn_edge) begin
                                        ev1  = mk_event(EV_BUTTON, btn_key, 3'd0, 1'b0,
                                                        '0, '0, '0, '0);
                                        ev_n = 2'd2;
                                    end
                                end else if (btn_edge) begin
                                    ev0  = mk_event(EV_BUTTON, btn_key, 3'd0, 1'b0,
                                                    '0, '0, '0, '0);
                                    ev_n = 2'd1;
                                end
                            end
                        end else if (csi_key != K_NONE) begin
                            ev0  = mk_event(EV_KEY, csi_key, csi_mods, csi_hold,
                                            '0, '0, '0, '0);
                            ev_n = 2'd1;
                        end
                    end
                end
                default: ;
            endcase
        end
        if (ev_n == 2'd1) ev0.last = 1'b1;
        if (ev_n == 2'd2) ev1.last = 1'b1;
    end

    // ----------------------------------------------------------- handshakes
    assign pop             = (r_count != '0) && i_out_ready;
    assign count_after_pop = r_count - {{FIFO_AW{1'b0}}, pop};
    assign proc            = r_in_valid && (r_count <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
    assign o_in_ready      = !r_in_valid || proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain  <= 4'd10;
            r_clamp <= 8'd100;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_GAIN:  r_gain  <= i_cfg_data[3:0];
                CFG_CLAMP: r_clamp <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_GROUND;
            r_total    <= '0;
            r_accum    <= '0;
            r_prefix   <= PFX_NONE;
            r_last_col <= '0;
            r_last_row <= '0;
            r_tracking <= 1'b0;
            r_down     <= '0;
        end else if (proc) begin
            r_mode     <= n_mode;
            r_total    <= n_total;
            r_accum    <= n_accum;
            r_prefix   <= n_prefix;
            r_last_col <= n_last_col;
            r_last_row <= n_last_row;
            r_tracking <= n_tracking;
            r_down     <= n_down;
        end
        if (proc) begin
            r_pv <= n_pv;
        end
    end

    // ----------------------------------------------------------- event queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_rd    <= r_rd + FIFO_AW'(pop);
            r_wr    <= proc ? r_wr + FIFO_AW'(ev_n) : r_wr;
            r_count <= count_after_pop + (proc ? (FIFO_AW+1)'(ev_n) : '0);
        end
        if (proc && ev_n != 2'd0) begin
            r_fifo[r_wr] <= ev0;
        end
        if (proc && ev_n == 2'd2) begin
            r_fifo[r_wr + FIFO_AW'(1)] <= ev1;
        end
    end

    assign o_out_valid     = (r_count != '0);
    assign o_event_kind    = r_fifo[r_rd].kind;
    assign o_key_id        = r_fifo[r_rd].key;
    assign o_mod_bits      = r_fifo[r_rd].mods;
    assign o_hold_long     = r_fifo[r_rd].hold;
    assign o_move_x        = r_fifo[r_rd].mx;
    assign o_move_y        = r_fifo[r_rd].my;
    assign o_report_first  = r_fifo[r_rd].r1;
    assign o_report_second = r_fifo[r_rd].r2;
    assign o_last_of_run   = r_fifo[r_rd].last;

    // ------------------------------------------------------------ assertions
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("event queue overflow");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != (FIFO_AW+1)'(FIFO_DEPTH)) |-> (FIFO_AW'(r_wr - r_rd) == r_count[FIFO_AW-1:0]))
        else $error("queue pointers and count disagree");

    a_byte_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !proc) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("pending byte lost while queue full");

    a_tracking_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> !$fell(r_tracking))
        else $error("mouse tracking dropped");

    a_buttons_need_tracking: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_down != 3'd0) |-> r_tracking)
        else $error("button held without tracking");

endmodule
